// ===== rtl/priority_ready_queue_defines.svh =====
// assertion macros for the priority ready queue
`ifndef PRIORITY_READY_QUEUE_DEFINES_SVH
`define PRIORITY_READY_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PRQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define PRQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PRQ_ASSERT_IMP(label, ante, cons, msg)
`define PRQ_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/prq_pkg.sv =====
package prq_pkg;

  localparam int MAX_TASKS_DEF      = 32;
  localparam int NUM_PRIORITIES_DEF = 32;

  localparam int FUNC_W   = 2;
  localparam int TASK_W   = 5;
  localparam int PRIO_W   = 5;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 6;
  localparam int HEAD_W   = 6;

  localparam logic [FUNC_W-1:0] FN_PUSH   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_POP    = 2'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;
  localparam logic [FUNC_W-1:0] FN_REPRIO = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ALREADY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTQ    = 2'd3;

  typedef struct packed {
    logic [TASK_W-1:0]   result_task;
    logic                result_valid;
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   queue_size;
    logic [HEAD_W-1:0]   head_priority;
  } result_t;

endpackage

// ===== rtl/prq_order_mem.sv =====
module prq_order_mem #(
  parameter int DEPTH = prq_pkg::MAX_TASKS_DEF,
  parameter int WIDTH = prq_pkg::TASK_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/prq_prio_mem.sv =====
module prq_prio_mem #(
  parameter int DEPTH = prq_pkg::MAX_TASKS_DEF,
  parameter int WIDTH = prq_pkg::PRIO_W
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] written;
  logic [WIDTH-1:0] rdata_q;
  logic             rvld_q;

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (we) begin
      written[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
    rvld_q  <= written[raddr];
  end

  assign rdata = rvld_q ? rdata_q : '0;

endmodule

// ===== rtl/prq_ctrl.sv =====
module prq_ctrl #(
  parameter int MAX_TASKS      = prq_pkg::MAX_TASKS_DEF,
  parameter int NUM_PRIORITIES = prq_pkg::NUM_PRIORITIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [prq_pkg::FUNC_W-1:0]        func,
  input  logic [prq_pkg::TASK_W-1:0]        task_id,
  input  logic [prq_pkg::PRIO_W-1:0]        priority_req,
  output logic                              res_valid,
  input  logic                              res_stall,
  output prq_pkg::result_t                  res,
  output logic                              om_we,
  output logic [$clog2(MAX_TASKS)-1:0]      om_waddr,
  output logic [$clog2(MAX_TASKS)-1:0]      om_wdata,
  output logic [$clog2(MAX_TASKS)-1:0]      om_raddr,
  input  logic [$clog2(MAX_TASKS)-1:0]      om_rdata,
  output logic                              pm_we,
  output logic [$clog2(MAX_TASKS)-1:0]      pm_waddr,
  output logic [$clog2(NUM_PRIORITIES)-1:0] pm_wdata,
  output logic [$clog2(MAX_TASKS)-1:0]      pm_raddr,
  input  logic [$clog2(NUM_PRIORITIES)-1:0] pm_rdata
);

  localparam int TW = $clog2(MAX_TASKS);
  localparam int PW = $clog2(NUM_PRIORITIES);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int HW = $clog2(NUM_PRIORITIES + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_REM   = 4'd2;
  localparam logic [3:0] S_INS   = 4'd3;
  localparam logic [3:0] S_H1    = 4'd4;
  localparam logic [3:0] S_H2    = 4'd5;
  localparam logic [3:0] S_H3    = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [3:0]                    state;
  logic [prq_pkg::FUNC_W-1:0]    op_func;
  logic [TW-1:0]                 op_tid;
  logic                          op_known;
  logic [PW-1:0]                 op_pr;
  logic [prq_pkg::STATUS_W-1:0]  status_r;
  logic [TW-1:0]                 rtask;
  logic                          rvalid;
  logic [CW-1:0]                 count;
  logic [HW-1:0]                 head;
  logic [MAX_TASKS-1:0]          queued;
  logic [CW-1:0]                 scan_i;
  logic                          p1_v;
  logic [TW-1:0]                 p1_idx;
  logic                          found;
  logic [TW-1:0]                 removed;
  logic                          issue_done;
  logic                          a_v;
  logic                          a_bottom;
  logic [TW-1:0]                 a_idx;
  logic                          b_v;
  logic                          b_bottom;
  logic [TW-1:0]                 b_idx;
  logic [TW-1:0]                 b_slot;

  logic [PW-1:0] pr_sat;
  logic [CW-1:0] ins_k;
  logic          d_hit;
  logic          c_stop;

  always_comb begin
    if (int'(priority_req) >= NUM_PRIORITIES) begin
      pr_sat = PW'(NUM_PRIORITIES - 1);
    end else begin
      pr_sat = PW'(priority_req);
    end
  end

  assign ins_k  = scan_i - CW'(1);
  assign d_hit  = (op_func == prq_pkg::FN_POP) ? (p1_idx == '0) : (om_rdata == op_tid);
  assign c_stop = b_bottom || (pm_rdata <= op_pr);

  // slot walk addresses
  always_comb begin
    om_we    = 1'b0;
    om_waddr = '0;
    om_wdata = '0;
    om_raddr = '0;
    case (state)
      S_REM: begin
        om_raddr = scan_i[TW-1:0];
        if (p1_v && found) begin
          om_we    = 1'b1;
          om_waddr = p1_idx - TW'(1);
          om_wdata = om_rdata;
        end
      end
      S_INS: begin
        om_raddr = ins_k[TW-1:0];
        if (b_v) begin
          om_we    = 1'b1;
          om_waddr = b_bottom ? '0 : b_idx + TW'(1);
          om_wdata = c_stop ? op_tid : b_slot;
        end
      end
      default: begin
        om_raddr = '0;
      end
    endcase
  end

  assign pm_raddr = om_rdata;
  assign pm_we    = (state == S_START) && op_known &&
                    (((op_func == prq_pkg::FN_PUSH) && !queued[op_tid]) ||
                     (op_func == prq_pkg::FN_REPRIO));
  assign pm_waddr = op_tid;
  assign pm_wdata = op_pr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      queued <= '0;
      p1_v   <= 1'b0;
      a_v    <= 1'b0;
      b_v    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_func  <= func;
            op_tid   <= TW'(task_id);
            op_known <= (int'(task_id) < MAX_TASKS);
            op_pr    <= pr_sat;
            status_r <= prq_pkg::ST_OK;
            rtask    <= '0;
            rvalid   <= 1'b0;
            state    <= S_START;
          end
        end
        S_START: begin
          scan_i     <= '0;
          p1_v       <= 1'b0;
          found      <= 1'b0;
          a_v        <= 1'b0;
          b_v        <= 1'b0;
          issue_done <= 1'b0;
          state      <= S_H1;
          if (op_func == prq_pkg::FN_POP) begin
            if (count == '0) begin
              status_r <= prq_pkg::ST_EMPTY;
            end else begin
              state <= S_REM;
            end
          end else if (!op_known) begin
            status_r <= prq_pkg::ST_NOTQ;
          end else begin
            case (op_func)
              prq_pkg::FN_PUSH: begin
                if (queued[op_tid]) begin
                  status_r <= prq_pkg::ST_ALREADY;
                end else begin
                  scan_i <= count;
                  state  <= S_INS;
                end
              end
              prq_pkg::FN_REMOVE: begin
                if (!queued[op_tid]) begin
                  status_r <= prq_pkg::ST_NOTQ;
                end else begin
                  state <= S_REM;
                end
              end
              default: begin
                if (queued[op_tid]) begin
                  state <= S_REM;
                end
              end
            endcase
          end
        end
        S_REM: begin
          if (scan_i < count) begin
            p1_v   <= 1'b1;
            p1_idx <= scan_i[TW-1:0];
            scan_i <= scan_i + CW'(1);
          end else begin
            p1_v <= 1'b0;
          end
          if (p1_v && d_hit) begin
            found   <= 1'b1;
            removed <= om_rdata;
          end
          if (!p1_v && (scan_i == count)) begin
            count           <= count - CW'(1);
            queued[removed] <= 1'b0;
            if (op_func == prq_pkg::FN_POP) begin
              rtask  <= removed;
              rvalid <= 1'b1;
            end
            if (op_func == prq_pkg::FN_REPRIO) begin
              scan_i     <= count - CW'(1);
              a_v        <= 1'b0;
              b_v        <= 1'b0;
              issue_done <= 1'b0;
              state      <= S_INS;
            end else begin
              state <= S_H1;
            end
          end
        end
        S_INS: begin
          // walk from the tail, shifting entries of greater priority up one slot
          if (!issue_done) begin
            a_v <= 1'b1;
            if (scan_i != '0) begin
              a_bottom <= 1'b0;
              a_idx    <= ins_k[TW-1:0];
              scan_i   <= ins_k;
            end else begin
              a_bottom   <= 1'b1;
              issue_done <= 1'b1;
            end
          end else begin
            a_v <= 1'b0;
          end
          b_v      <= a_v;
          b_bottom <= a_bottom;
          b_idx    <= a_idx;
          b_slot   <= om_rdata;
          if (b_v && c_stop) begin
            count          <= count + CW'(1);
            queued[op_tid] <= 1'b1;
            a_v            <= 1'b0;
            b_v            <= 1'b0;
            state          <= S_H1;
          end
        end
        S_H1: begin
          if (count == '0) begin
            head  <= HW'(NUM_PRIORITIES);
            state <= S_DONE;
          end else begin
            state <= S_H2;
          end
        end
        S_H2: begin
          state <= S_H3;
        end
        S_H3: begin
          head  <= HW'(pm_rdata);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!res_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req_stall = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res.result_task   = prq_pkg::TASK_W'(rtask);
    res.result_valid  = rvalid;
    res.status        = status_r;
    res.queue_size    = prq_pkg::SIZE_W'(count);
    res.head_priority = prq_pkg::HEAD_W'(head);
  end

endmodule

// ===== rtl/priority_ready_queue.sv =====
// channel   valid      stall      payload
// request   req_valid  req_stall  func, task_id, priority_req
// response  rsp_valid  rsp_stall  result_task, result_valid, status, queue_size,
//                                 head_priority
//
// one operation at a time; a pop or remove walks all n queued entries
// (one slot read per cycle while compacting), a push walks the m entries
// that sit behind the new slot, and a reprioritize walks both; early outs
// skip the walk
// reset clears the entry count, queued flags and priority written flags at once
// a held result register does not stop the next operation; it waits to hand over
module priority_ready_queue #(
  parameter int MAX_TASKS      = prq_pkg::MAX_TASKS_DEF,
  parameter int NUM_PRIORITIES = prq_pkg::NUM_PRIORITIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [prq_pkg::FUNC_W-1:0]    func,
  input  logic [prq_pkg::TASK_W-1:0]    task_id,
  input  logic [prq_pkg::PRIO_W-1:0]    priority_req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [prq_pkg::TASK_W-1:0]    result_task,
  output logic                          result_valid,
  output logic [prq_pkg::STATUS_W-1:0]  status,
  output logic [prq_pkg::SIZE_W-1:0]    queue_size,
  output logic [prq_pkg::HEAD_W-1:0]    head_priority
);

`include "priority_ready_queue_defines.svh"

  localparam int TW = $clog2(MAX_TASKS);
  localparam int PW = $clog2(NUM_PRIORITIES);
  localparam logic [prq_pkg::HEAD_W-1:0] EMPTY_HEAD =
    prq_pkg::HEAD_W'(NUM_PRIORITIES % (2 ** prq_pkg::HEAD_W));

  logic             om_we;
  logic [TW-1:0]    om_waddr;
  logic [TW-1:0]    om_wdata;
  logic [TW-1:0]    om_raddr;
  logic [TW-1:0]    om_rdata;
  logic             pm_we;
  logic [TW-1:0]    pm_waddr;
  logic [PW-1:0]    pm_wdata;
  logic [TW-1:0]    pm_raddr;
  logic [PW-1:0]    pm_rdata;

  logic             res_valid;
  logic             res_stall;
  prq_pkg::result_t res;
  logic             out_v;
  prq_pkg::result_t out_res;

  logic             pop_rsp;
  logic             empty_rsp;
  logic             empty_ok;

  prq_ctrl #(
    .MAX_TASKS      (MAX_TASKS),
    .NUM_PRIORITIES (NUM_PRIORITIES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .func         (func),
    .task_id      (task_id),
    .priority_req (priority_req),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .res          (res),
    .om_we        (om_we),
    .om_waddr     (om_waddr),
    .om_wdata     (om_wdata),
    .om_raddr     (om_raddr),
    .om_rdata     (om_rdata),
    .pm_we        (pm_we),
    .pm_waddr     (pm_waddr),
    .pm_wdata     (pm_wdata),
    .pm_raddr     (pm_raddr),
    .pm_rdata     (pm_rdata)
  );

  prq_order_mem #(
    .DEPTH (MAX_TASKS),
    .WIDTH (TW)
  ) u_order_mem (
    .clk   (clk),
    .we    (om_we),
    .waddr (om_waddr),
    .wdata (om_wdata),
    .raddr (om_raddr),
    .rdata (om_rdata)
  );

  prq_prio_mem #(
    .DEPTH (MAX_TASKS),
    .WIDTH (PW)
  ) u_prio_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (pm_we),
    .waddr (pm_waddr),
    .wdata (pm_wdata),
    .raddr (pm_raddr),
    .rdata (pm_rdata)
  );

  assign res_stall = out_v && rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (res_valid && !res_stall) begin
      out_v <= 1'b1;
    end else if (!rsp_stall) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && !res_stall) begin
      out_res <= res;
    end
  end

  assign rsp_valid     = out_v;
  assign result_task   = out_res.result_task;
  assign result_valid  = out_res.result_valid;
  assign status        = out_res.status;
  assign queue_size    = out_res.queue_size;
  assign head_priority = out_res.head_priority;

  assign pop_rsp   = rsp_valid && result_valid;
  assign empty_rsp = rsp_valid && (status == prq_pkg::ST_EMPTY);
  assign empty_ok  = (queue_size == '0) && (head_priority == EMPTY_HEAD) && !result_valid;

  `PRQ_ASSERT_NXT(a_busy_after_transfer, req_valid && !req_stall, req_stall, "not busy")
  `PRQ_ASSERT_IMP(a_pop_status_ok, pop_rsp, status == prq_pkg::ST_OK, "pop with error status")
  `PRQ_ASSERT_IMP(a_empty_pop, empty_rsp, empty_ok, "empty pop reports a non-empty queue")
  `PRQ_ASSERT_NXT(a_res_hold, res_valid && res_stall, res_valid, "result dropped while held")

endmodule

// ===== dv/prq_order_checker.sv =====
`timescale 1ns / 100ps

module prq_order_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic                          req_stall,
  input  logic [prq_pkg::FUNC_W-1:0]    func,
  input  logic [prq_pkg::TASK_W-1:0]    task_id,
  input  logic [prq_pkg::PRIO_W-1:0]    priority_req,
  input  logic                          rsp_valid,
  input  logic                          rsp_stall,
  input  logic [prq_pkg::TASK_W-1:0]    result_task,
  input  logic                          result_valid,
  input  logic [prq_pkg::STATUS_W-1:0]  status,
  input  logic [prq_pkg::SIZE_W-1:0]    queue_size,
  input  logic [prq_pkg::HEAD_W-1:0]    head_priority,
  output int                            fail_count,
  output int                            pending,
  output int                            rsp_count,
  output int                            pop_count,
  output int                            peak_size
);
  import prq_pkg::*;

  logic [PRIO_W-1:0] task_prio [MAX_TASKS_DEF];
  bit                task_queued [MAX_TASKS_DEF];
  logic [TASK_W-1:0] ready_order [$];
  result_t           results_due [$];
  result_t           due;
  int                errs;

  function automatic void unlink_task(logic [TASK_W-1:0] t);
    int pos;
    pos = 0;
    while (pos < ready_order.size() && ready_order[pos] != t) pos++;
    if (pos < ready_order.size()) ready_order.delete(pos);
    task_queued[t] = 1'b0;
  endfunction

  // goes behind every entry whose priority is not greater
  function automatic void link_task(logic [TASK_W-1:0] t);
    int pos;
    pos = 0;
    if (ready_order.size() >= MAX_TASKS_DEF) return;
    while (pos < ready_order.size() && task_prio[ready_order[pos]] <= task_prio[t]) pos++;
    ready_order.insert(pos, t);
    task_queued[t] = 1'b1;
  endfunction

  function automatic result_t next_sched_result(logic [FUNC_W-1:0] f,
                                                logic [TASK_W-1:0] t,
                                                logic [PRIO_W-1:0] p);
    result_t r;
    r = '0;
    r.status = ST_OK;
    case (f)
      FN_POP: begin
        if (ready_order.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.result_task  = ready_order[0];
          r.result_valid = 1'b1;
          unlink_task(ready_order[0]);
        end
      end
      FN_PUSH: begin
        if (task_queued[t]) begin
          r.status = ST_ALREADY;
        end else begin
          task_prio[t] = p;
          link_task(t);
        end
      end
      FN_REMOVE: begin
        if (!task_queued[t]) r.status = ST_NOTQ;
        else unlink_task(t);
      end
      FN_REPRIO: begin
        task_prio[t] = p;
        if (task_queued[t]) begin
          unlink_task(t);
          link_task(t);
        end
      end
      default: ;
    endcase
    r.queue_size = SIZE_W'(ready_order.size());
    if (ready_order.size() > 0) r.head_priority = HEAD_W'(task_prio[ready_order[0]]);
    else r.head_priority = HEAD_W'(NUM_PRIORITIES_DEF);
    return r;
  endfunction

  function automatic int field_diff(string name, int expv, int actv);
    if (expv == actv) return 0;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
    return 1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TASKS_DEF; i++) begin
        task_prio[i]   = '0;
        task_queued[i] = 1'b0;
      end
      ready_order.delete();
      results_due.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_count++;
        if (results_due.size() == 0) begin
          fail_count++;
          $display("%0t: response transfer with nothing expected, expected none, actual task %0d status %0d",
                   $time, result_task, status);
        end else begin
          due = results_due.pop_front();
          errs = field_diff("result_task", due.result_task, result_task)
               + field_diff("result_valid", due.result_valid, result_valid)
               + field_diff("status", due.status, status)
               + field_diff("queue_size", due.queue_size, queue_size)
               + field_diff("head_priority", due.head_priority, head_priority);
          if (errs != 0) fail_count++;
          if (due.result_valid) pop_count++;
        end
      end
      if (req_valid && !req_stall) begin
        results_due.push_back(next_sched_result(func, task_id, priority_req));
        if (ready_order.size() > peak_size) peak_size = ready_order.size();
      end
    end
    pending = results_due.size();
  end

endmodule

// ===== dv/tb_priority_ready_queue.sv =====
`timescale 1ns / 100ps

module tb_priority_ready_queue;
  import prq_pkg::*;

  localparam int RANDOM_ITEMS = 1280;
  localparam int TAIL_ITEMS   = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT  = 1000000;

  logic                clk;
  logic                rst;
  logic                req_valid;
  logic                req_stall;
  logic [FUNC_W-1:0]   func;
  logic [TASK_W-1:0]   task_id;
  logic [PRIO_W-1:0]   priority_req;
  logic                rsp_valid;
  logic                rsp_stall;
  logic [TASK_W-1:0]   result_task;
  logic                result_valid;
  logic [STATUS_W-1:0] status;
  logic [SIZE_W-1:0]   queue_size;
  logic [HEAD_W-1:0]   head_priority;

  int fail_count, pending, rsp_count, pop_count, peak_size;
  int op_count [4];
  int cycles;
  bit quiet_tail;
  bit hold_off_req;

  priority_ready_queue dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .func         (func),
    .task_id      (task_id),
    .priority_req (priority_req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .result_task  (result_task),
    .result_valid (result_valid),
    .status       (status),
    .queue_size   (queue_size),
    .head_priority(head_priority)
  );

  prq_order_checker order_chk (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .func         (func),
    .task_id      (task_id),
    .priority_req (priority_req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .result_task  (result_task),
    .result_valid (result_valid),
    .status       (status),
    .queue_size   (queue_size),
    .head_priority(head_priority),
    .fail_count   (fail_count),
    .pending      (pending),
    .rsp_count    (rsp_count),
    .pop_count    (pop_count),
    .peak_size    (peak_size)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles with %0d responses outstanding", cycles, pending);
    $display("Simulation FAILED");
    $finish;
  end

  // response side: random stall bursts, one long hold-off, none in the tail
  initial begin
    rsp_stall = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (quiet_tail) begin
        rsp_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        rsp_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task automatic issue(input logic [FUNC_W-1:0] f, input logic [TASK_W-1:0] t,
                       input logic [PRIO_W-1:0] p);
    int gap;
    gap = 0;
    if (!quiet_tail && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 14);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid    <= 1'b1;
    func         <= f;
    task_id      <= t;
    priority_req <= p;
    op_count[f]++;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // mostly a few close priorities so that ties are common
  function automatic logic [PRIO_W-1:0] pick_prio();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return PRIO_W'($urandom_range(0, 3));
    if (r < 8) return PRIO_W'($urandom_range(0, 31));
    if (r == 8) return '0;
    return '1;
  endfunction

  // phase 0 fills, phase 1 mixes, phase 2 drains
  function automatic logic [FUNC_W-1:0] pick_op(int phase);
    int r;
    r = $urandom_range(0, 99);
    case (phase)
      0: begin
        if (r < 70) return FN_PUSH;
        if (r < 80) return FN_REPRIO;
        if (r < 90) return FN_REMOVE;
        return FN_POP;
      end
      1: begin
        if (r < 35) return FN_PUSH;
        if (r < 70) return FN_POP;
        if (r < 85) return FN_REMOVE;
        return FN_REPRIO;
      end
      default: begin
        if (r < 10) return FN_PUSH;
        if (r < 75) return FN_POP;
        if (r < 88) return FN_REMOVE;
        return FN_REPRIO;
      end
    endcase
  endfunction

  initial begin
    int n;
    int phase;
    logic [FUNC_W-1:0] op;
    logic [TASK_W-1:0] tid;
    rst          = 1'b1;
    req_valid    = 1'b0;
    func         = FN_PUSH;
    task_id      = '0;
    priority_req = '0;
    quiet_tail   = 1'b0;
    hold_off_req = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    issue(FN_POP, 5'd0, 5'd0);
    issue(FN_REMOVE, 5'd5, 5'd0);
    issue(FN_REPRIO, 5'd7, 5'd31);
    issue(FN_PUSH, 5'd0, 5'd31);
    issue(FN_PUSH, 5'd31, 5'd0);
    issue(FN_PUSH, 5'd3, 5'd31);
    issue(FN_PUSH, 5'd0, 5'd5);
    issue(FN_PUSH, 5'd7, 5'd16);
    issue(FN_PUSH, 5'd10, 5'd16);
    issue(FN_REPRIO, 5'd7, 5'd16);
    issue(FN_REPRIO, 5'd31, 5'd31);
    issue(FN_REMOVE, 5'd3, 5'd0);
    issue(FN_REMOVE, 5'd3, 5'd0);
    issue(FN_PUSH, 5'd21, 5'd21);
    issue(FN_PUSH, 5'd10, 5'd10);
    repeat (6) issue(FN_POP, 5'd31, 5'd31);
    issue(FN_PUSH, 5'd10, 5'd10);
    issue(FN_REPRIO, 5'd10, 5'd0);
    issue(FN_REMOVE, 5'd10, 5'd31);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      phase = (n / 60) % 3;
      if (n == 300) hold_off_req = 1'b1;
      if (n == RANDOM_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
      op = pick_op(phase);
      if (phase == 0 && $urandom_range(0, 1) == 1) tid = TASK_W'(n);
      else tid = TASK_W'($urandom_range(0, 31));
      issue(op, tid, pick_prio());
    end
    req_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: push %0d, pop %0d, remove %0d, reprioritize %0d",
             op_count[FN_PUSH] + op_count[FN_POP] + op_count[FN_REMOVE] + op_count[FN_REPRIO],
             op_count[FN_PUSH], op_count[FN_POP], op_count[FN_REMOVE], op_count[FN_REPRIO]);
    $display("checked %0d responses, %0d tasks dequeued, peak queue depth %0d",
             rsp_count, pop_count, peak_size);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== priority_ready_queue.f =====
+incdir+rtl
rtl/prq_pkg.sv
rtl/prq_order_mem.sv
rtl/prq_prio_mem.sv
rtl/prq_ctrl.sv
rtl/priority_ready_queue.sv
dv/prq_order_checker.sv
dv/tb_priority_ready_queue.sv
